// ----- rtl/gsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared constants for the glyph shelf allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package gsa_pkg;
  localparam int NUM_FORMATS_DEF   = 3;
  localparam int MAX_PAGES_DEF     = 8;
  localparam int MAX_SURFACES_DEF  = 128;
  localparam int SEARCH_WINDOW_DEF = 100;

  localparam int ROW_W = 18;
  localparam logic [ROW_W-1:0] ROW_MAX = 18'h3FFFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PAGE_FULL = 2'd1;
  localparam logic [1:0] ST_SURF_FULL = 2'd2;

  localparam logic [1:0] CFG_WMARGIN = 2'd0;
  localparam logic [1:0] CFG_HMARGIN = 2'd1;
  localparam logic [1:0] CFG_GPS     = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/gsa_ram.sv -----
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/glyph_shelf_allocator.sv -----
// ----------------------------------------------------------------------------
// glyph_shelf_allocator
// Best-fit shelf packing of glyph rectangles, one table per glyph format.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// config    in         cfg_we               cfg_index, cfg_data
// command   in         start & !busy        func, glyph_kind, glyph_*, line_height ...
// result    out        done (one cycle)     status, page_index ... opened_*
//
// An allocate item holds busy while it runs: the page scan reads and checks
// one page width at a time, and the surface scan reads the height/fill
// memory one entry per cycle for the newest SEARCH_WINDOW-1 surfaces at
// most. done rises in the same cycle that busy drops. A clear item never
// raises busy and returns its result in the next cycle.
// Reset clears the page counts; the other memories need no clearing since
// only entries below a count are read.
// The receiver cannot stall: done pulses for one cycle with the result.
`default_nettype none
module glyph_shelf_allocator #(
  parameter int NUM_FORMATS   = gsa_pkg::NUM_FORMATS_DEF,
  parameter int MAX_PAGES     = gsa_pkg::MAX_PAGES_DEF,
  parameter int MAX_SURFACES  = gsa_pkg::MAX_SURFACES_DEF,
  parameter int SEARCH_WINDOW = gsa_pkg::SEARCH_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [1:0]  glyph_kind,
  input  wire logic [11:0] glyph_width,
  input  wire logic [11:0] glyph_height,
  input  wire logic [11:0] line_height,
  input  wire logic [11:0] bmp_rows,
  input  wire logic [11:0] em_size,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       page_index,
  output logic [6:0]       surface_index,
  output logic [17:0]      top_row,
  output logic [17:0]      bottom_row,
  output logic [17:0]      surface_rows,
  output logic [12:0]      page_width,
  output logic             opened_page,
  output logic             opened_surface
);
  localparam int FW  = (NUM_FORMATS > 1) ? $clog2(NUM_FORMATS) : 1;
  localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SW  = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int SCW = $clog2(MAX_SURFACES + 1);
  localparam int NSLOT = NUM_FORMATS * MAX_PAGES;
  localparam int SLW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int NROW = NSLOT * (2 ** SW);
  localparam int RAW = SLW + SW;
  localparam int RW = gsa_pkg::ROW_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRD   = 4'd1;  // page width read returned and checked
  localparam logic [3:0] S_PCHK  = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;  // surface count read issued
  localparam logic [3:0] S_CCHK  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;  // surface row reads streaming
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;  // chosen surface read issued
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;

  // configuration
  logic [7:0] width_margin, height_margin;
  logic [6:0] glyphs_per_surface;
  always_ff @(posedge clk) begin
    if (rst) begin
      width_margin <= '0; height_margin <= '0; glyphs_per_surface <= 7'd16;
    end else if (cfg_we) begin
      if (cfg_index == gsa_pkg::CFG_WMARGIN) width_margin <= cfg_data;
      if (cfg_index == gsa_pkg::CFG_HMARGIN) height_margin <= cfg_data;
      if (cfg_index == gsa_pkg::CFG_GPS) glyphs_per_surface <= cfg_data[6:0];
    end
  end

  logic [3:0] state;
  logic [PCW-1:0] page_count [NUM_FORMATS];
  logic [FW-1:0]  fmt;
  logic [11:0] gw, gh, fh, br, fs;
  logic [PCW-1:0] np, p;
  logic [SCW-1:0] ns;
  logic [SCW-1:0] si;       // surfaces left to read
  logic [SCW-1:0] scan_cnt; // surfaces left to compare
  logic [SW-1:0]  raddr_s, cmp_s, best_s;
  logic           best_ok;
  logic [RW-1:0]  least_slack;
  logic           new_page, new_surf;
  logic [12:0]    pw;
  logic [RW-1:0]  hgt;
  logic [19:0]    prod;     // up to 7+13 bits
  logic [12:0]    rowh;

  wire [SLW-1:0] pslot = SLW'(fmt * MAX_PAGES + p[PW-1:0]);

  // memories
  logic pw_we; logic [SLW-1:0] pw_ra; logic [12:0] pw_rd;
  logic sc_we; logic [SCW-1:0] sc_wd; logic [SCW-1:0] sc_rd;
  logic rh_we; logic [RAW-1:0] rh_wa, rh_ra; logic [2*RW-1:0] rh_wd, rh_rd;

  gsa_ram #(.WIDTH(13), .DEPTH(NSLOT)) u_pw (
    .clk, .we(pw_we), .waddr(pslot), .wdata(pw), .raddr(pw_ra), .rdata(pw_rd));
  gsa_ram #(.WIDTH(SCW), .DEPTH(NSLOT)) u_sc (
    .clk, .we(sc_we), .waddr(pslot), .wdata(sc_wd), .raddr(pslot), .rdata(sc_rd));
  gsa_ram #(.WIDTH(2*RW), .DEPTH(NROW)) u_rows (
    .clk, .we(rh_we), .waddr(rh_wa), .wdata(rh_wd), .raddr(rh_ra), .rdata(rh_rd));

  assign pw_ra = SLW'(fmt * MAX_PAGES + p[PW-1:0]);
  assign rh_ra = {pslot, raddr_s};

  // waste of the entry being compared; height below fill counts as no room
  wire [RW-1:0] r_h = rh_rd[2*RW-1:RW];
  wire [RW-1:0] r_f = rh_rd[RW-1:0];
  wire          fits = (r_h >= r_f) && ((r_h - r_f) >= RW'(gh));
  wire [RW-1:0] waste = r_h - r_f;

  wire [RW-1:0] top_new = new_surf ? '0 : r_f;
  wire [RW:0] bot_sum_n = {1'b0, top_new} + (RW+1)'(gh);
  wire [RW-1:0] bot_n = bot_sum_n[RW] ? gsa_pkg::ROW_MAX : bot_sum_n[RW-1:0];
  wire [RW-1:0] hgt_sel = new_surf ? hgt : r_h;

  wire [12:0] r0 = 13'(height_margin) + 13'(fh);
  wire [12:0] r1 = (r0 <= 13'(height_margin)) ? r0 + 13'(br) : r0;
  wire [12:0] r2 = (r1 <= 13'(height_margin)) ? r1 + 13'(fs) : r1;

  wire [FW-1:0] fmt_in = (32'(glyph_kind) >= NUM_FORMATS) ?
                         FW'(NUM_FORMATS - 1) : FW'(glyph_kind);

  // scan the newest surfaces, one short of the window
  wire [SCW-1:0] scan_len = (32'(sc_rd) > SEARCH_WINDOW - 1) ?
                            SCW'(SEARCH_WINDOW - 1) : sc_rd;

  // items that end with a result in the next cycle
  wire clear_go  = (state == S_IDLE) && start && func;
  wire page_full = (state == S_PRD) && (p == np) && (32'(np) >= MAX_PAGES);
  wire surf_full = (state == S_DEC) && !best_ok && (32'(ns) >= MAX_SURFACES);

  task automatic emit_fail(input logic [1:0] code);
    status <= code; page_index <= '0; surface_index <= '0;
    top_row <= '0; bottom_row <= '0; surface_rows <= '0; page_width <= '0;
    opened_page <= 1'b0; opened_surface <= 1'b0;
  endtask

  assign busy = (state != S_IDLE);
  assign rh_wa = {pslot, best_s};
  assign rh_wd = {hgt_sel, bot_n};
  assign rh_we = (state == S_WB);
  assign pw_we = (state == S_WB) && new_page;
  assign sc_we = (state == S_WB) && (new_page || new_surf);
  assign sc_wd = new_surf ? ns + SCW'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= clear_go || page_full || surf_full || (state == S_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < NUM_FORMATS; k++) page_count[k] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          if (func) begin
            for (int k = 0; k < NUM_FORMATS; k++) page_count[k] <= '0;
            emit_fail(gsa_pkg::ST_OK);
          end else begin
            fmt <= fmt_in; gw <= glyph_width; gh <= glyph_height;
            fh <= line_height; br <= bmp_rows; fs <= em_size;
            np <= page_count[fmt_in]; p <= '0;
            new_page <= 1'b0; new_surf <= 1'b0;
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          // pw_rd is stale here: wait for the read issued with this p
          state <= S_PRD;
        end
        S_PRD: begin
          if (p == np) begin
            if (32'(np) >= MAX_PAGES) begin
              emit_fail(gsa_pkg::ST_PAGE_FULL); state <= S_IDLE;
            end else begin
              new_page <= 1'b1; new_surf <= 1'b1; ns <= '0;
              pw <= 13'(gw) + 13'(width_margin);
              rowh <= r2; best_s <= '0; state <= S_MUL;
            end
          end else if (pw_rd >= 13'(gw)) begin
            pw <= pw_rd; state <= S_CRD;
          end else begin
            p <= p + PCW'(1); state <= S_PCHK;
          end
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          ns <= sc_rd;
          best_ok <= 1'b0; least_slack <= '1;
          if (scan_len == '0) state <= S_DEC;
          else begin
            raddr_s <= SW'(sc_rd - SCW'(1));
            cmp_s   <= SW'(sc_rd - SCW'(1));
            si <= scan_len;
            scan_cnt <= scan_len;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          // reads issued one per cycle; the compare trails the address through the read register
          if (si != scan_cnt || si == '0) begin
            if (fits && (!best_ok || waste < least_slack)) begin
              best_ok <= 1'b1; least_slack <= waste; best_s <= cmp_s;
            end
            cmp_s <= cmp_s - SW'(1);
            scan_cnt <= scan_cnt - SCW'(1);
            if (scan_cnt == SCW'(1)) state <= S_DEC;
          end
          if (si != '0) begin
            si <= si - SCW'(1);
            if (si != SCW'(1)) raddr_s <= raddr_s - SW'(1);
          end
        end
        S_DEC: begin
          if (best_ok) begin
            raddr_s <= best_s; state <= S_FRD;
          end else if (32'(ns) >= MAX_SURFACES) begin
            emit_fail(gsa_pkg::ST_SURF_FULL); state <= S_IDLE;
          end else begin
            new_surf <= 1'b1; best_s <= SW'(ns); rowh <= r2; state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 20'(glyphs_per_surface) * 20'(rowh);
          state <= S_FRD;
          raddr_s <= best_s;
        end
        S_FRD: begin
          if (new_surf) hgt <= (prod > 20'(gsa_pkg::ROW_MAX)) ?
                               gsa_pkg::ROW_MAX : prod[RW-1:0];
          state <= S_WB;
        end
        S_WB: begin
          if (new_page) page_count[fmt] <= np + PCW'(1);
          status <= gsa_pkg::ST_OK;
          page_index <= 3'(p); surface_index <= 7'(best_s);
          top_row <= top_new; bottom_row <= bot_n; surface_rows <= hgt_sel;
          page_width <= pw; opened_page <= new_page; opened_surface <= new_surf;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == gsa_pkg::ST_OK || status == gsa_pkg::ST_PAGE_FULL ||
              status == gsa_pkg::ST_SURF_FULL))
    else $error("unknown status code");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != gsa_pkg::ST_OK) |-> (!opened_page && !opened_surface))
    else $error("failed item opened storage");
  a_page_open: assert property (@(posedge clk) disable iff (rst)
    (done && opened_page) |-> opened_surface) else $error("page without surface");
endmodule
`default_nettype wire

// ----- dv/glyph_shelf_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// glyph_shelf_allocator_tb
// Self-checking testbench for the glyph shelf allocator. It drives allocate
// and clear items through the start/busy port. A scoreboard keeps its own copy
// of the page and surface tables and predicts each result. Each done strobe
// is checked against the oldest prediction. The run goes through several
// register settings, and idle gaps of random length fall between items.
// ----------------------------------------------------------------------------
`default_nettype none
module glyph_shelf_allocator_tb;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_CLEAR = 1'b1;
  localparam int NFMT   = gsa_pkg::NUM_FORMATS_DEF;
  localparam int NPAGE  = gsa_pkg::MAX_PAGES_DEF;
  localparam int NSURF  = gsa_pkg::MAX_SURFACES_DEF;
  localparam int WINDOW = gsa_pkg::SEARCH_WINDOW_DEF;

  typedef struct packed {
    logic        func;
    logic [1:0]  fmt;
    logic [11:0] gw;
    logic [11:0] gh;
    logic [11:0] fh;
    logic [11:0] br;
    logic [11:0] fs;
  } glyph_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  page;
    logic [6:0]  surf;
    logic [17:0] top;
    logic [17:0] bottom;
    logic [17:0] rows;
    logic [12:0] pwidth;
    logic        opened_page;
    logic        opened_surf;
  } placement_t;

  // Shadow of the atlas tables; predicts where each glyph lands.
  class shelf_scoreboard;
    int unsigned wmargin, hmargin, gps;
    int unsigned pg_cnt[NFMT];
    int unsigned pg_w[NFMT*NPAGE];
    int unsigned sf_cnt[NFMT*NPAGE];
    int unsigned sf_h[NFMT*NPAGE*NSURF];
    int unsigned sf_fill[NFMT*NPAGE*NSURF];
    placement_t  pending[$];
    int          mismatches;
    int          checked;
    int          n_clear, n_page_full, n_surf_full, n_new_surf;

    function new();
      wmargin = 0;
      hmargin = 0;
      gps = 16;
      mismatches = 0;
      checked = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (pg_cnt[i]) pg_cnt[i] = 0;
      foreach (sf_cnt[i]) sf_cnt[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        gsa_pkg::CFG_WMARGIN: wmargin = 32'(val);
        gsa_pkg::CFG_HMARGIN: hmargin = 32'(val);
        gsa_pkg::CFG_GPS:     gps = 32'(val[6:0]);
        default: ;
      endcase
    endfunction

    function int unsigned sat(longint unsigned v);
      return (v > gsa_pkg::ROW_MAX) ? 32'(gsa_pkg::ROW_MAX) : 32'(v);
    endfunction

    // Predict the placement of one accepted item and queue it.
    function void note_item(glyph_req_t it);
      placement_t r;
      int unsigned fmt, np, p, slot, ns, base, s, rowh, top;
      int best, i;
      longint waste, least_slack;
      bit new_page;
      r = '0;
      new_page = 0;
      if (it.func == FN_CLEAR) begin
        wipe();
        n_clear++;
        pending.push_back(r);
        return;
      end
      fmt = (32'(it.fmt) >= NFMT) ? NFMT - 1 : 32'(it.fmt);
      np = pg_cnt[fmt];
      for (p = 0; p < np; p++)
        if (pg_w[fmt*NPAGE + p] >= it.gw) break;
      if (p == np) begin
        if (np >= NPAGE) begin
          r.status = gsa_pkg::ST_PAGE_FULL;
          n_page_full++;
          pending.push_back(r);
          return;
        end
        new_page = 1;
      end
      slot = fmt*NPAGE + p;
      base = slot*NSURF;
      best = -1;
      ns = 0;
      if (!new_page) begin
        ns = sf_cnt[slot];
        least_slack = 64'h7fff_ffff_ffff_ffff;
        // Scan newest first; strict less-than keeps the newer one on a tie.
        for (i = int'(ns) - 1; i >= 0 && i > int'(ns) - WINDOW; i--) begin
          waste = longint'(sf_h[base+i]) - longint'(sf_fill[base+i]);
          if (waste >= longint'(it.gh) && waste < least_slack) begin
            best = i;
            least_slack = waste;
          end
        end
      end
      if (best < 0 && ns >= NSURF) begin
        r.status = gsa_pkg::ST_SURF_FULL;
        n_surf_full++;
        pending.push_back(r);
        return;
      end
      if (new_page) begin
        pg_w[slot] = it.gw + wmargin;
        sf_cnt[slot] = 0;
        pg_cnt[fmt] = np + 1;
      end
      if (best < 0) begin
        rowh = hmargin + it.fh;
        if (rowh <= hmargin) rowh += it.br;
        if (rowh <= hmargin) rowh += it.fs;
        s = ns;
        sf_h[base+s] = sat(longint'(gps) * rowh);
        sf_fill[base+s] = 0;
        sf_cnt[slot] = ns + 1;
        r.opened_surf = 1;
        n_new_surf++;
      end else begin
        s = best;
      end
      top = sf_fill[base+s];
      sf_fill[base+s] = sat(longint'(top) + it.gh);
      r.status      = gsa_pkg::ST_OK;
      r.page        = 3'(p);
      r.surf        = 7'(s);
      r.top         = 18'(top);
      r.bottom      = 18'(sf_fill[base+s]);
      r.rows        = 18'(sf_h[base+s]);
      r.pwidth      = 13'(pg_w[slot]);
      r.opened_page = new_page;
      pending.push_back(r);
    endfunction

    function void check_result(placement_t got);
      placement_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status !== exp.status || got.page !== exp.page || got.surf !== exp.surf ||
          got.top !== exp.top || got.bottom !== exp.bottom || got.rows !== exp.rows ||
          got.pwidth !== exp.pwidth || got.opened_page !== exp.opened_page ||
          got.opened_surf !== exp.opened_surf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d\n  expected %p\n  actual   %p", checked, exp, got);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        start, busy, done;
  logic        func;
  logic [1:0]  glyph_kind;
  logic [11:0] glyph_width, glyph_height, line_height, bmp_rows, em_size;
  logic [1:0]  status;
  logic [2:0]  page_index;
  logic [6:0]  surface_index;
  logic [17:0] top_row, bottom_row, surface_rows;
  logic [12:0] page_width;
  logic        opened_page, opened_surface;

  shelf_scoreboard sb;
  int n_items;
  bit gaps_on;

  glyph_shelf_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .func(func), .glyph_kind(glyph_kind), .glyph_width(glyph_width),
    .glyph_height(glyph_height), .line_height(line_height),
    .bmp_rows(bmp_rows), .em_size(em_size),
    .done(done), .status(status), .page_index(page_index),
    .surface_index(surface_index), .top_row(top_row), .bottom_row(bottom_row),
    .surface_rows(surface_rows), .page_width(page_width),
    .opened_page(opened_page), .opened_surface(opened_surface)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // Results cannot be held off: sample every strobe.
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result({status, page_index, surface_index, top_row, bottom_row,
                       surface_rows, page_width, opened_page, opened_surface});
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Present one item and hold it until accepted; drop start only on a gap.
  task automatic send_item(glyph_req_t it);
    int g;
    func         <= it.func;
    glyph_kind   <= it.fmt;
    glyph_width  <= it.gw;
    glyph_height <= it.gh;
    line_height  <= it.fh;
    bmp_rows     <= it.br;
    em_size      <= it.fs;
    start        <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
    n_items++;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_all(logic [7:0] wm, logic [7:0] hm, logic [7:0] gps);
    write_reg(gsa_pkg::CFG_WMARGIN, wm);
    write_reg(gsa_pkg::CFG_HMARGIN, hm);
    write_reg(gsa_pkg::CFG_GPS, gps);
  endtask

  function automatic glyph_req_t alloc(logic [1:0] fmt, logic [11:0] gw, logic [11:0] gh,
                                       logic [11:0] fh, logic [11:0] br, logic [11:0] fs);
    return glyph_req_t'{FN_ALLOC, fmt, gw, gh, fh, br, fs};
  endfunction

  function automatic logic [11:0] rnd_dim(int lo_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 12'd0;
    if (r < 80) return 12'($urandom_range(1, lo_max));
    return 12'($urandom_range(0, 4095));
  endfunction

  // Random item: mostly allocations with small sizes so surfaces get reused.
  function automatic glyph_req_t rnd_item();
    glyph_req_t it;
    it.func = ($urandom_range(0, 99) < 3) ? FN_CLEAR : FN_ALLOC;
    it.fmt  = 2'($urandom_range(0, 3));
    it.gw   = rnd_dim(200);
    it.gh   = rnd_dim(40);
    it.fh   = rnd_dim(30);
    it.br   = rnd_dim(30);
    it.fs   = rnd_dim(30);
    return it;
  endfunction

  task automatic random_phase(int count);
    gaps_on = $urandom_range(0, 3) != 0;
    repeat (count) send_item(rnd_item());
    drain();
  endtask

  initial begin
    int k;
    sb = new();
    n_items = 0;
    gaps_on = 1;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    start = 1'b0; func = FN_ALLOC; glyph_kind = '0;
    glyph_width = '0; glyph_height = '0; line_height = '0;
    bmp_rows = '0; em_size = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset defaults, row-height fallbacks, clamped format, extremes.
    send_item(alloc(2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0));
    send_item(alloc(2'd0, 12'd16, 12'd10, 12'd12, 12'd0, 12'd0));
    send_item(alloc(2'd1, 12'd20, 12'd8, 12'd0, 12'd9, 12'd0));
    send_item(alloc(2'd1, 12'd20, 12'd8, 12'd0, 12'd0, 12'd11));
    send_item(alloc(2'd3, 12'd30, 12'd5, 12'd7, 12'd7, 12'd7));
    send_item(alloc(2'd2, 12'd25, 12'd5, 12'd7, 12'd7, 12'd7));
    send_item(alloc(2'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095));
    send_item(glyph_req_t'{FN_CLEAR, 2'd3, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    drain();

    // Saturated surface height and widest page, then zero rows per surface.
    set_all(8'd255, 8'd255, 8'd64);
    send_item(alloc(2'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0));
    send_item(alloc(2'd0, 12'd100, 12'd4095, 12'd1, 12'd0, 12'd0));
    send_item(alloc(2'd1, 12'd10, 12'd300, 12'd0, 12'd0, 12'd0));
    drain();
    set_all(8'd0, 8'd0, 8'd0);
    send_item(alloc(2'd2, 12'd10, 12'd3, 12'd5, 12'd5, 12'd5));
    send_item(alloc(2'd2, 12'd10, 12'd0, 12'd5, 12'd5, 12'd5));
    drain();

    // Page table full: nine ever wider glyphs on a cleared format.
    set_all(8'd0, 8'd2, 8'd4);
    send_item(glyph_req_t'{FN_CLEAR, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    for (k = 1; k <= 9; k++) send_item(alloc(2'd1, 12'(k*10), 12'd1, 12'd4, 12'd0, 12'd0));
    // Taller-than-surface glyph on a fresh page.
    send_item(alloc(2'd2, 12'd5, 12'd500, 12'd1, 12'd0, 12'd0));
    drain();

    // Surface table full: every glyph overflows its one-row surface.
    set_all(8'd3, 8'd0, 8'd1);
    gaps_on = 0;
    for (k = 0; k < NSURF + 2; k++) send_item(alloc(2'd0, 12'd8, 12'd50, 12'd1, 12'd0, 12'd0));
    drain();
    send_item(glyph_req_t'{FN_CLEAR, 2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0});
    drain();

    // Random phases across settings; each ends with a full drain.
    set_all(8'd0, 8'd0, 8'd16);
    random_phase(150);
    set_all(8'd255, 8'd255, 8'd64);
    random_phase(120);
    set_all(8'd0, 8'd0, 8'd1);
    random_phase(115);
    for (k = 0; k < 3; k++) begin
      set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(1, 64)));
      random_phase(70);
    end

    start <= 1'b0;
    k = 0;
    while (sb.pending.size() != 0 && k < 2000) begin
      @(posedge clk);
      k++;
    end
    repeat (150) @(posedge clk);
    if (sb.pending.size() != 0) sb.mismatches++;

    $display("Ran %0d items: %0d clears, %0d page-full, %0d surface-full, %0d new surfaces.",
             n_items, sb.n_clear, sb.n_page_full, sb.n_surf_full, sb.n_new_surf);
    $display("Checked %0d results, %0d mismatches, %0d left unanswered.",
             sb.checked, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
